### hw/rtl/bve_pkg.sv
// Shared types, constants and codes for the bounded vector engine.
`timescale 1ns / 1ps

package bve_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 7;
    localparam int LEN_W    = 7;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RESIZE = 3'd5;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_PUSH,
        OP_FIND,
        OP_READ,
        OP_WRITE,
        OP_RESIZE,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [POS_W-1:0]   position;
        logic [DATA_W-1:0]  value;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_FIND,
        ST_READ,
        ST_FILL
    } t_state;

endpackage

### hw/rtl/bve_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bve_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bve_front.sv
// Input side: accepts items, decodes the action and queues commands for the back end.
`timescale 1ns / 1ps

module bve_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bve_pkg::ACTION_W-1:0]  i_action,
    input  logic [bve_pkg::POS_W-1:0]     i_position,
    input  logic [bve_pkg::DATA_W-1:0]    i_value,
    output logic                          o_cmd_valid,
    output bve_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_pop
);

    import bve_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    t_cmd       dec_cmd;
    logic       push;
    logic       pop;

    always_comb begin
        dec_cmd.position = i_position;
        dec_cmd.value    = i_value;
        case (i_action)
            ACT_INSERT: dec_cmd.op = OP_INSERT;
            ACT_PUSH:   dec_cmd.op = OP_PUSH;
            ACT_FIND:   dec_cmd.op = OP_FIND;
            ACT_READ:   dec_cmd.op = OP_READ;
            ACT_WRITE:  dec_cmd.op = OP_WRITE;
            ACT_RESIZE: dec_cmd.op = OP_RESIZE;
            default:    dec_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_stall  = (r_fill == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

### hw/rtl/bve_back.sv
// Execution side: sequences each command over the entry memory and registers the result.
`timescale 1ns / 1ps

module bve_back #(
    parameter int CAPACITY = bve_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_valid,
    input  bve_pkg::t_cmd                       i_cmd,
    output logic                                o_cmd_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_ok,
    output logic                                o_found,
    output logic signed [bve_pkg::IDX_W-1:0]    o_found_index,
    output logic signed [bve_pkg::DATA_W-1:0]   o_read_data,
    output logic [bve_pkg::LEN_W-1:0]           o_length
);

    import bve_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [AW-1:0] A_ONE = AW'(1);
    localparam logic [AW-1:0] A_TWO = AW'(2);
    localparam logic [CW-1:0] C_ONE = CW'(1);
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_end, n_end;
    logic [DATA_W-1:0]  r_val, n_val;
    logic               r_ok, n_ok;

    logic               r_out_valid, n_out_valid;
    logic               r_o_ok, r_o_found;
    logic [IDX_W-1:0]   r_o_fidx;
    logic [DATA_W-1:0]  r_o_rdata;
    logic [LEN_W-1:0]   r_o_len;

    logic               fin;
    logic               fin_ok, fin_found;
    logic [IDX_W-1:0]   fin_fidx;
    logic [DATA_W-1:0]  fin_rdata;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [DATA_W-1:0]  wdata, rdata;

    logic               out_free;
    logic [XW-1:0]      pos_x, cnt_x, ins_x, new_x;

    bve_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Only the back end fills the output register, so once a command is taken
    // with the register free it stays free until that command finishes.
    assign out_free = !r_out_valid || !i_out_stall;
    assign pos_x    = XW'(i_cmd.position);
    assign cnt_x    = XW'(r_count);
    assign ins_x    = (i_cmd.op == OP_PUSH) ? cnt_x : pos_x;
    assign new_x    = (pos_x > CAP_X) ? CAP_X : pos_x;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_end       = r_end;
        n_val       = r_val;
        n_ok        = r_ok;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd_pop   = 1'b0;
        fin         = 1'b0;
        fin_ok      = 1'b0;
        fin_found   = 1'b0;
        fin_fidx    = '0;
        fin_rdata   = '0;
        we          = 1'b0;
        waddr       = r_idx;
        wdata       = '0;
        raddr       = r_idx + A_ONE;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    n_val     = i_cmd.value;
                    case (i_cmd.op)
                        OP_INSERT, OP_PUSH: begin
                            if (ins_x > cnt_x || cnt_x == CAP_X) begin
                                fin = 1'b1;
                            end else if (ins_x == cnt_x) begin
                                we      = 1'b1;
                                waddr   = AW'(r_count);
                                wdata   = i_cmd.value;
                                n_count = r_count + C_ONE;
                                fin     = 1'b1;
                                fin_ok  = 1'b1;
                            end else begin
                                // Move entries up from the top, one per cycle.
                                raddr   = AW'(r_count - C_ONE);
                                n_idx   = AW'(r_count);
                                n_pos   = AW'(ins_x);
                                n_state = ST_SHIFT;
                            end
                        end
                        OP_FIND: begin
                            if (r_count == '0) begin
                                fin      = 1'b1;
                                fin_ok   = 1'b1;
                                fin_fidx = '1;
                            end else begin
                                raddr   = '0;
                                n_idx   = '0;
                                n_state = ST_FIND;
                            end
                        end
                        OP_READ: begin
                            if (pos_x < cnt_x) begin
                                raddr   = AW'(i_cmd.position);
                                n_state = ST_READ;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        OP_WRITE: begin
                            fin = 1'b1;
                            if (pos_x < cnt_x) begin
                                we     = 1'b1;
                                waddr  = AW'(i_cmd.position);
                                wdata  = i_cmd.value;
                                fin_ok = 1'b1;
                            end
                        end
                        OP_RESIZE: begin
                            n_ok = !(pos_x > CAP_X);
                            if (new_x > cnt_x) begin
                                n_idx   = AW'(r_count);
                                n_end   = CW'(new_x);
                                n_state = ST_FILL;
                            end else begin
                                n_count = CW'(new_x);
                                fin     = 1'b1;
                                fin_ok  = !(pos_x > CAP_X);
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = rdata;
                raddr = r_idx - A_TWO;
                if ((r_idx - A_ONE) == r_pos) begin
                    n_state = ST_PLACE;
                end else begin
                    n_idx = r_idx - A_ONE;
                end
            end
            ST_PLACE: begin
                we      = 1'b1;
                waddr   = r_pos;
                wdata   = r_val;
                n_count = r_count + C_ONE;
                fin     = 1'b1;
                fin_ok  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_FIND: begin
                if (rdata == r_val) begin
                    fin       = 1'b1;
                    fin_ok    = 1'b1;
                    fin_found = 1'b1;
                    fin_fidx  = IDX_W'(r_idx);
                    n_state   = ST_IDLE;
                end else if ((CW'(r_idx) + C_ONE) == r_count) begin
                    fin      = 1'b1;
                    fin_ok   = 1'b1;
                    fin_fidx = '1;
                    n_state  = ST_IDLE;
                end else begin
                    n_idx = r_idx + A_ONE;
                end
            end
            ST_READ: begin
                fin       = 1'b1;
                fin_ok    = 1'b1;
                fin_rdata = rdata;
                n_state   = ST_IDLE;
            end
            ST_FILL: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = '0;
                if ((CW'(r_idx) + C_ONE) == r_end) begin
                    n_count = r_end;
                    fin     = 1'b1;
                    fin_ok  = r_ok;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + A_ONE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (fin) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_end <= n_end;
        r_val <= n_val;
        r_ok  <= n_ok;
        if (fin) begin
            r_o_ok    <= fin_ok;
            r_o_found <= fin_found;
            r_o_fidx  <= fin_fidx;
            r_o_rdata <= fin_rdata;
            r_o_len   <= LEN_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_o_ok;
    assign o_found       = r_o_found;
    assign o_found_index = r_o_fidx;
    assign o_read_data   = r_o_rdata;
    assign o_length      = r_o_len;

endmodule

### hw/rtl/bounded_vector_engine.sv
// Top level of the bounded vector engine: command queue front end and execution back end.
//
// A bounded array of signed 32-bit words with a current length. Each input
// transfer carries an action (insert, push, find, read, write, resize),
// a position and a value; each one produces exactly one output transfer with
// ok, found, found_index, read_data and the length after the action.
// Input and output use valid/stall handshakes. A two-entry command queue sits
// behind the input, so up to two items are taken while the back end is busy.
// Items are executed one at a time by a sequencer around a single-port-write,
// registered-read entry memory, which sets the timing:
//   read: the address is issued, then the registered data is returned;
//   write, push, shrinking resize, failed actions: finished when the command is taken;
//   insert at p: entries from the top down to p moved one per cycle, then the value placed;
//   find: one entry compared per cycle until a hit or the last entry;
//   growing resize: one entry zero-filled per cycle up to the new length.
// The result sits in an output register; while the receiver stalls it holds,
// and the back end does not start a new command until it is free.
// Reset empties the queue and sets the length to zero; entry contents are not
// cleared and need no clearing pass, since only entries below the length are
// ever read.
`timescale 1ns / 1ps

module bounded_vector_engine #(
    parameter int CAPACITY = bve_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bve_pkg::ACTION_W-1:0]        i_action,
    input  logic [bve_pkg::POS_W-1:0]           i_position,
    input  logic signed [bve_pkg::DATA_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_ok,
    output logic                                o_found,
    output logic signed [bve_pkg::IDX_W-1:0]    o_found_index,
    output logic signed [bve_pkg::DATA_W-1:0]   o_read_data,
    output logic [bve_pkg::LEN_W-1:0]           o_length
);

    import bve_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    bve_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    bve_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_read_data   (o_read_data),
        .o_length      (o_length)
    );

endmodule

### hw/rtl/bve_check.sv
// Port-level checker for the bounded vector engine and its bind to the top level.
`timescale 1ns / 1ps

module bve_check #(
    parameter int CAPACITY = bve_pkg::CAPACITY_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic [bve_pkg::ACTION_W-1:0]        i_action,
    input logic [bve_pkg::POS_W-1:0]           i_position,
    input logic signed [bve_pkg::DATA_W-1:0]   i_value,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_ok,
    input logic                                o_found,
    input logic signed [bve_pkg::IDX_W-1:0]    o_found_index,
    input logic signed [bve_pkg::DATA_W-1:0]   o_read_data,
    input logic [bve_pkg::LEN_W-1:0]           o_length
);

    // A stalled result must stay offered with the same length and ok flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_length) && $stable(o_ok))
        else $error("stalled result dropped or changed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A find hit is a successful find, which never carries read data.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_ok && o_read_data == 0)
        else $error("found flag with bad companion fields");

    // The length never exceeds the capacity where the length field can show it.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY >= 128) || (int'(o_length) <= CAPACITY))
        else $error("length above capacity");

endmodule

bind bounded_vector_engine bve_check #(.CAPACITY(CAPACITY)) u_check (.*);
